// ----- rtl/ssts_pkg.sv -----
// ----------------------------------------------------------------------------
// ssts_pkg
// Shared types and constants for the sorted size table snap block
// ----------------------------------------------------------------------------
package ssts_pkg;

  // default configuration of the table
  localparam int TABLE_DEPTH_DEF = 64;
  localparam int SIZE_BITS_DEF   = 20;

  // item kinds carried on the input tuser
  localparam logic [1:0] KIND_CLEAR  = 2'd0;
  localparam logic [1:0] KIND_INSERT = 2'd1;
  localparam logic [1:0] KIND_MAP    = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_MAP_ENABLE    = 2'd0;
  localparam logic [1:0] CFG_ROUND_NEAREST = 2'd1;

  // command broadcast from the sequencer to every cell
  typedef struct packed {
    logic cmp;      // latch the per-cell compare against the item size
    logic clr;      // empty the table
    logic ins;      // shift in the item size at its sorted place
    logic nearest;  // nearest-neighbor selection instead of round up
  } ssts_cmd_t;

endpackage

// ----- rtl/ssts_cell.sv -----
// ----------------------------------------------------------------------------
// ssts_cell
// One table slot: holds an entry, shifts right on insert, votes on snapping
// ----------------------------------------------------------------------------
module ssts_cell import ssts_pkg::*; #(
  parameter int SIZE_BITS = SIZE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ssts_cmd_t            cmd,
  input  logic [SIZE_BITS-1:0] v,
  input  logic [SIZE_BITS-1:0] left_val,
  input  logic                 left_valid,
  input  logic                 left_lt,
  input  logic                 right_valid,
  output logic [SIZE_BITS-1:0] val,
  output logic                 valid,
  output logic                 lt,
  output logic                 hit,
  output logic [SIZE_BITS-1:0] hit_val,
  output logic [SIZE_BITS-1:0] last_val
);

  logic [SIZE_BITS-1:0] val_r;
  logic                 valid_r;
  logic                 lt_r;
  logic [SIZE_BITS-1:0] val_nxt;
  logic                 valid_nxt;
  logic                 lt_nxt;
  logic                 ge;
  logic                 left_ge;
  logic [SIZE_BITS-1:0] dist_lo;
  logic [SIZE_BITS-1:0] dist_hi;
  logic                 pick_left;

  // an entry is below the item size only if it holds data
  assign ge      = valid_r && !lt_r;
  assign left_ge = left_valid && !left_lt;

  // entry update: clear, shift from the left, or take the new size
  always_comb begin
    val_nxt   = val_r;
    valid_nxt = valid_r;
    lt_nxt    = lt_r;
    if (cmd.cmp) begin
      lt_nxt = valid_r && (val_r < v);
    end
    if (cmd.clr) begin
      valid_nxt = 1'b0;
    end else if (cmd.ins) begin
      if (!left_lt) begin
        val_nxt   = left_val;
        valid_nxt = left_valid;
      end else if (!lt_r) begin
        val_nxt   = v;
        valid_nxt = 1'b1;
      end
    end
  end

  // control flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      lt_r    <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      lt_r    <= lt_nxt;
    end
  end

  // entry payload
  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  // first entry at or above the size owns the snap decision
  assign hit       = ge && !left_ge;
  assign dist_lo   = v - left_val;
  assign dist_hi   = val_r - v;
  // tie goes to the lower neighbor
  assign pick_left = cmd.nearest && left_valid && !(dist_lo > dist_hi);
  assign hit_val   = hit ? (pick_left ? left_val : val_r) : '0;
  assign last_val  = (valid_r && !right_valid) ? val_r : '0;

  assign val   = val_r;
  assign valid = valid_r;
  assign lt    = lt_r;

endmodule

// ----- rtl/sorted_size_table_snap.sv -----
// ----------------------------------------------------------------------------
// sorted_size_table_snap
// Ascending size table with insert, clear and snap-to-entry lookup
// ----------------------------------------------------------------------------
// The table lives in a row of TABLE_DEPTH cells, each holding one entry. An
// item passes through the states ST_IDLE, ST_CMP and ST_UPD: it is accepted,
// then every cell compares its entry with the size, and in ST_UPD the row
// either shifts to open the insertion slot or the snapped size is picked
// out of the row and loaded into the output register. ST_UPD waits while an
// earlier result is still held on the output. Clear empties the whole row at
// once. Configuration writes are always accepted.
module sorted_size_table_snap import ssts_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int SIZE_BITS   = SIZE_BITS_DEF,
  parameter int CNT_W       = $clog2(TABLE_DEPTH + 1),
  parameter int IN_W        = ((SIZE_BITS + 7) / 8) * 8,
  parameter int OUT_W       = ((SIZE_BITS + 2 + CNT_W + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  // input stream
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,   // size_value, zero padded
  input  logic [1:0]       in_tuser,   // kind
  // result stream
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata,  // mapped_size, clamped_high,
                                       // insert_dropped, entry_count, padding
  // configuration writes
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic             cfg_data
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CMP  = 2'd1;
  localparam logic [1:0] ST_UPD  = 2'd2;

  logic [1:0]           state_r, state_nxt;
  logic [1:0]           kind_r;
  logic [SIZE_BITS-1:0] v_r;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic                 map_enable_r;
  logic                 round_nearest_r;
  logic                 out_valid_r;
  logic [SIZE_BITS-1:0] out_size_r, out_size_nxt;
  logic                 out_clamp_r, out_clamp_nxt;
  logic                 out_drop_r, out_drop_nxt;
  logic                 in_take;
  logic                 finish;
  logic                 full;
  ssts_cmd_t            cmd;

  logic [SIZE_BITS-1:0] cell_val   [TABLE_DEPTH];
  logic                 cell_valid [TABLE_DEPTH];
  logic                 cell_lt    [TABLE_DEPTH];
  logic                 cell_hit   [TABLE_DEPTH];
  logic [SIZE_BITS-1:0] cell_hval  [TABLE_DEPTH];
  logic [SIZE_BITS-1:0] cell_lval  [TABLE_DEPTH];
  logic [SIZE_BITS-1:0] hit_or;
  logic [SIZE_BITS-1:0] last_or;
  logic                 any_hit;

  assign in_tready = (state_r == ST_IDLE);
  assign in_take   = in_tvalid && in_tready;
  assign finish    = (state_r == ST_UPD) && (!out_valid_r || out_tready);
  assign full      = (count_r == CNT_W'(TABLE_DEPTH));
  assign cfg_ready = 1'b1;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_take) state_nxt = ST_CMP;
      ST_CMP:  state_nxt = ST_UPD;
      ST_UPD:  if (finish) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // commands to the cell row
  always_comb begin
    cmd.cmp     = (state_r == ST_CMP);
    cmd.clr     = finish && (kind_r == KIND_CLEAR);
    cmd.ins     = finish && (kind_r == KIND_INSERT) && !full;
    cmd.nearest = round_nearest_r;
  end

  // cell row
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    logic [SIZE_BITS-1:0] lv;
    logic                 lvalid;
    logic                 llt;
    logic                 rvalid;
    if (i == 0) begin : g_head
      assign lv     = '0;
      assign lvalid = 1'b0;
      assign llt    = 1'b1;
    end else begin : g_body
      assign lv     = cell_val[i-1];
      assign lvalid = cell_valid[i-1];
      assign llt    = cell_lt[i-1];
    end
    if (i == TABLE_DEPTH - 1) begin : g_tail
      assign rvalid = 1'b0;
    end else begin : g_mid
      assign rvalid = cell_valid[i+1];
    end
    ssts_cell #(
      .SIZE_BITS (SIZE_BITS)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .cmd         (cmd),
      .v           (v_r),
      .left_val    (lv),
      .left_valid  (lvalid),
      .left_lt     (llt),
      .right_valid (rvalid),
      .val         (cell_val[i]),
      .valid       (cell_valid[i]),
      .lt          (cell_lt[i]),
      .hit         (cell_hit[i]),
      .hit_val     (cell_hval[i]),
      .last_val    (cell_lval[i])
    );
  end

  // collect the one-hot votes of the row
  always_comb begin
    hit_or  = '0;
    last_or = '0;
    any_hit = 1'b0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      hit_or  = hit_or | cell_hval[i];
      last_or = last_or | cell_lval[i];
      any_hit = any_hit | cell_hit[i];
    end
  end

  // result and count for the finishing item
  always_comb begin
    out_size_nxt  = '0;
    out_clamp_nxt = 1'b0;
    out_drop_nxt  = 1'b0;
    count_nxt     = count_r;
    unique case (kind_r)
      KIND_CLEAR: count_nxt = '0;
      KIND_INSERT: begin
        if (full) begin
          out_drop_nxt = 1'b1;
        end else begin
          count_nxt = count_r + CNT_W'(1);
        end
      end
      KIND_MAP: begin
        if (!map_enable_r || count_r == '0) begin
          out_size_nxt = v_r;
        end else if (any_hit) begin
          out_size_nxt = hit_or;
        end else begin
          out_size_nxt  = last_or;
          out_clamp_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      count_r         <= '0;
      out_valid_r     <= 1'b0;
      map_enable_r    <= 1'b0;
      round_nearest_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (finish) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_MAP_ENABLE:    map_enable_r    <= cfg_data;
          CFG_ROUND_NEAREST: round_nearest_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // item and result payload
  always_ff @(posedge clk) begin
    if (in_take) begin
      kind_r <= in_tuser;
      v_r    <= in_tdata[SIZE_BITS-1:0];
    end
    if (finish) begin
      out_size_r  <= out_size_nxt;
      out_clamp_r <= out_clamp_nxt;
      out_drop_r  <= out_drop_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'({count_r, out_drop_r, out_clamp_r, out_size_r});

endmodule
